/* src/button_press_classifier_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the button press classifier
// Shared clocking and reset handling for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// Check that holds in the same cycle as its condition.
`define BPC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that holds in the cycle after its condition.
`define BPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Constants, register defaults and codes of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned DEF_COUNT_WIDTH = 16;

  localparam int DEB_W   = 10;
  localparam int LONG_W  = 16;
  localparam int HALF_W  = 12;
  localparam int REP_W   = 4;
  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 2;
  localparam int FPH_W   = 5;
  localparam int EV_W    = 2;
  localparam int MODE_W  = 2;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [ADDR_W-1:0] REG_LONG     = 2'd1;
  localparam logic [ADDR_W-1:0] REG_HALF     = 2'd2;
  localparam logic [ADDR_W-1:0] REG_REPEATS  = 2'd3;

  // register reset values
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 10'd30;
  localparam logic [LONG_W-1:0] LONG_RST     = 16'd1000;
  localparam logic [HALF_W-1:0] HALF_RST     = 12'd150;
  localparam logic [REP_W-1:0]  REPEATS_RST  = 4'd3;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAIT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FLASH = 2'd3;

  // press event codes
  localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EV_W-1:0] EV_SHORT  = 2'd1;
  localparam logic [EV_W-1:0] EV_LONG   = 2'd2;
  localparam logic [EV_W-1:0] EV_REJECT = 2'd3;

endpackage

/* src/button_press_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounces an active-low button sampled once per tick transaction and
// classifies presses as short (toggles LED one), long (flashes all LEDs)
// or rejected bounces.
// ----------------------------------------------------------------------------
// A tick's result is registered and appears in the cycle after accept.
// Throughput: one tick per cycle unless stalled; the state update is a single
//   counter increment and compare between the state and result registers.
// in_stall_o rises only while a result waits and out_stall_i is high.
// Reset (async, active low): idle, LED one state dark, config at defaults.
// ----------------------------------------------------------------------------
`include "button_press_classifier_assert.svh"

module button_press_classifier #(
  parameter int unsigned COUNT_WIDTH = bpc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [bpc_pkg::ADDR_W-1:0] cfg_addr_i,
  input  logic [bpc_pkg::CFG_W-1:0]  cfg_wdata_i,
  // tick input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       button_level_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       led_one_level_o,
  output logic                       led_two_level_o,
  output logic                       led_three_level_o,
  output logic [bpc_pkg::EV_W-1:0]   press_event_o
);

  // Timer must hold the saturated hold count, the 16-bit long threshold
  // and the 12-bit flash phase length.
  localparam int TW = (COUNT_WIDTH > bpc_pkg::LONG_W) ? COUNT_WIDTH : bpc_pkg::LONG_W;
  localparam logic [TW-1:0] CntMax = TW'({COUNT_WIDTH{1'b1}});

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [bpc_pkg::DEB_W-1:0]  deb_q;
  logic [bpc_pkg::LONG_W-1:0] long_q;
  logic [bpc_pkg::HALF_W-1:0] half_q;
  logic [bpc_pkg::REP_W-1:0]  rep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= bpc_pkg::DEBOUNCE_RST;
      long_q <= bpc_pkg::LONG_RST;
      half_q <= bpc_pkg::HALF_RST;
      rep_q  <= bpc_pkg::REPEATS_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bpc_pkg::REG_DEBOUNCE: deb_q  <= cfg_wdata_i[bpc_pkg::DEB_W-1:0];
        bpc_pkg::REG_LONG:     long_q <= cfg_wdata_i[bpc_pkg::LONG_W-1:0];
        bpc_pkg::REG_HALF:     half_q <= cfg_wdata_i[bpc_pkg::HALF_W-1:0];
        bpc_pkg::REG_REPEATS:  rep_q  <= cfg_wdata_i[bpc_pkg::REP_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero in debounce, half period or repeats behaves as one.
  logic [TW-1:0]              deb_ext, half_ext, long_ext;
  logic [bpc_pkg::REP_W-1:0]  rep_eff;

  assign deb_ext  = (deb_q == '0)  ? TW'(1) : TW'(deb_q);
  assign half_ext = (half_q == '0) ? TW'(1) : TW'(half_q);
  assign long_ext = TW'(long_q);
  assign rep_eff  = (rep_q == '0)  ? bpc_pkg::REP_W'(1) : rep_q;

  // --------------------------------------------------------------------------
  // Handshake: single result register, input stalls only when it is held.
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic acc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign acc        = in_valid_i & ~in_stall_o;

  // --------------------------------------------------------------------------
  // Classifier state
  // --------------------------------------------------------------------------
  logic [bpc_pkg::MODE_W-1:0] mode_q, mode_d;
  logic                       prev_q, prev_d;
  logic [TW-1:0]              cnt_q, cnt_d;
  logic [bpc_pkg::FPH_W-1:0]  fph_q, fph_d;
  logic                       tog_q, tog_d;
  logic                       led1_q, led1_d;
  logic [bpc_pkg::EV_W-1:0]   ev_d;
  logic [TW-1:0]              cnt_inc, cnt_sat;
  logic [bpc_pkg::FPH_W-1:0]  fph_inc;
  logic                       l1_d, l23_d;

  assign cnt_inc = cnt_q + TW'(1);
  assign cnt_sat = (cnt_q < CntMax) ? cnt_inc : cnt_q;
  assign fph_inc = fph_q + bpc_pkg::FPH_W'(1);

  always_comb begin
    mode_d = mode_q;
    prev_d = prev_q;
    cnt_d  = cnt_q;
    fph_d  = fph_q;
    tog_d  = tog_q;
    led1_d = led1_q;
    ev_d   = bpc_pkg::EV_NONE;

    case (mode_q)
      bpc_pkg::MODE_FLASH: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= half_ext) begin
          cnt_d = '0;
          fph_d = fph_inc;
          // two phases (lit, dark) per repeat
          if (fph_inc >= {rep_eff, 1'b0}) begin
            mode_d = bpc_pkg::MODE_IDLE;
            fph_d  = '0;
            led1_d = 1'b1;
            prev_d = 1'b0;
          end
        end
      end
      bpc_pkg::MODE_WAIT: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= deb_ext) begin
          cnt_d = '0;
          if (button_level_i) begin
            ev_d   = bpc_pkg::EV_REJECT;
            mode_d = bpc_pkg::MODE_IDLE;
            prev_d = 1'b0;
          end else begin
            mode_d = bpc_pkg::MODE_HOLD;
          end
        end
      end
      bpc_pkg::MODE_HOLD: begin
        cnt_d = cnt_sat;
        if (button_level_i) begin
          cnt_d = '0;
          if (cnt_sat >= long_ext) begin
            ev_d   = bpc_pkg::EV_LONG;
            mode_d = bpc_pkg::MODE_FLASH;
            fph_d  = '0;
          end else begin
            ev_d   = bpc_pkg::EV_SHORT;
            tog_d  = ~tog_q;
            led1_d = tog_q;   // LED is active low: lit when tog_q is clear
            mode_d = bpc_pkg::MODE_IDLE;
            prev_d = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // Idle edge detection; also runs on the tick that ends a flash.
    if ((mode_q == bpc_pkg::MODE_IDLE) ||
        ((mode_q == bpc_pkg::MODE_FLASH) && (mode_d == bpc_pkg::MODE_IDLE))) begin
      if (!button_level_i && prev_d) begin
        mode_d = bpc_pkg::MODE_WAIT;
        cnt_d  = '0;
        prev_d = 1'b0;
      end else begin
        prev_d = button_level_i;
      end
    end

    // LED pins: flash drives all three from the phase, else LED one only.
    if (mode_d == bpc_pkg::MODE_FLASH) begin
      l1_d  = fph_d[0];
      l23_d = fph_d[0];
    end else begin
      l1_d  = led1_d;
      l23_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bpc_pkg::MODE_IDLE;
      prev_q <= 1'b1;
      cnt_q  <= '0;
      fph_q  <= '0;
      tog_q  <= 1'b0;
      led1_q <= 1'b1;
    end else if (acc) begin
      mode_q <= mode_d;
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
      fph_q  <= fph_d;
      tog_q  <= tog_d;
      led1_q <= led1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                     l1_q, l2_q, l3_q;
  logic [bpc_pkg::EV_W-1:0] ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      l1_q <= l1_d;
      l2_q <= l23_d;
      l3_q <= l23_d;
      ev_q <= ev_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign led_one_level_o   = l1_q;
  assign led_two_level_o   = l2_q;
  assign led_three_level_o = l3_q;
  assign press_event_o     = ev_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BPC_ASSERT_NEXT(a_long_starts_flash, acc && (ev_d == bpc_pkg::EV_LONG),
    (mode_q == bpc_pkg::MODE_FLASH) && !led_one_level_o && !led_two_level_o,
    "long press did not start a lit flash phase")

  `BPC_ASSERT_NEXT(a_short_returns_idle,
    acc && ((ev_d == bpc_pkg::EV_SHORT) || (ev_d == bpc_pkg::EV_REJECT)),
    (mode_q == bpc_pkg::MODE_IDLE) && !prev_q,
    "handled press did not return to idle with low previous level")

  `BPC_ASSERT_NEXT(a_flash_end_dark,
    acc && (mode_q == bpc_pkg::MODE_FLASH) && (mode_d != bpc_pkg::MODE_FLASH),
    led1_q && led_one_level_o && $stable(tog_q),
    "flash end did not leave LED one dark with toggle kept")

  `BPC_ASSERT_NOW(a_hold_saturates, mode_q == bpc_pkg::MODE_HOLD, cnt_q <= CntMax,
    "hold count beyond saturation limit")

endmodule
